### hw/rtl/threshold_halftone_bit_packer_macros.svh
// Assertion helpers used by the checker file.
`ifndef THRESHOLD_HALFTONE_BIT_PACKER_MACROS_SVH
`define THRESHOLD_HALFTONE_BIT_PACKER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define THBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define THBP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/thbp_pkg.sv
`default_nettype none

package thbp_pkg;

  localparam int unsigned MAX_ROW_WIDTH = 4096;

  localparam int unsigned PixW       = 8;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LeftBitsW  = 4;
  localparam int unsigned RowWidthW  = 13;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned ROW_WIDTH_RESET = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_LEFT_BITS = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_ROW_WIDTH = 1'b1;

  typedef struct packed {
    logic             row_end;
    logic             last;
    logic [ByteW-1:0] data;
  } entry_t;

  // Results of one accepted pixel: up to two bytes, in order.
  typedef struct packed {
    logic [1:0] num;
    entry_t     first;
    entry_t     second;
  } push_t;

endpackage

`default_nettype wire

### hw/rtl/thbp_packer.sv
`default_nettype none

module thbp_packer #(
  parameter int unsigned MaxRowWidth = thbp_pkg::MAX_ROW_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [thbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [thbp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                           accept_i,
  input  wire logic [thbp_pkg::PixW-1:0]      contone_i,
  input  wire logic [thbp_pkg::PixW-1:0]      threshold_i,
  output thbp_pkg::push_t                     push_o
);

  localparam int unsigned PosW = $clog2(MaxRowWidth + 1);
  localparam int unsigned LenW = (PosW > thbp_pkg::RowWidthW) ? PosW : thbp_pkg::RowWidthW;

  logic [thbp_pkg::LeftBitsW-1:0] left_bits_q;
  logic [thbp_pkg::RowWidthW-1:0] row_width_q;
  logic [PosW-1:0]                pos_q, pos_d;
  logic [thbp_pkg::ByteW-1:0]     acc_q, acc_d;
  logic [2:0]                     bi_q, bi_d;

  logic [LenW-1:0]            width_ext, width_sat;
  logic [PosW-1:0]            row_len, lb_ext, pos0, pos1;
  logic [thbp_pkg::ByteW-1:0] acc0, acc1, acc2;
  logic [2:0]                 bi0, bi2;
  logic [3:0]                 bi1, main_low;
  logic                       row_empty, restart, pix, full;
  logic                       left_end, hit_len, main_end, flush_en, zero_en;
  logic [1:0]                 num;
  thbp_pkg::push_t            push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_bits_q <= '0;
      row_width_q <= thbp_pkg::RowWidthW'(thbp_pkg::ROW_WIDTH_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        thbp_pkg::REG_LEFT_BITS: left_bits_q <= cfg_wdata_i[thbp_pkg::LeftBitsW-1:0];
        thbp_pkg::REG_ROW_WIDTH: row_width_q <= cfg_wdata_i[thbp_pkg::RowWidthW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Saturate the row width, then stretch it to cover the left segment.
    width_ext = LenW'(row_width_q);
    width_sat = (width_ext > LenW'(MaxRowWidth)) ? LenW'(MaxRowWidth) : width_ext;
    lb_ext    = PosW'(left_bits_q);
    row_len   = (PosW'(width_sat) > lb_ext) ? PosW'(width_sat) : lb_ext;
    row_empty = (row_len == '0);

    // Drop a partial row left over from an older register setting.
    restart = (pos_q >= row_len);
    pos0    = restart ? '0 : pos_q;
    acc0    = restart ? '0 : acc_q;
    bi0     = restart ? '0 : bi_q;

    pix  = (contone_i < threshold_i);
    acc1 = acc0 | (pix ? (8'h80 >> bi0) : 8'h00);
    bi1  = {1'b0, bi0} + 4'd1;
    full = bi1[3];
    acc2 = full ? '0 : acc1;
    bi2  = bi1[2:0];

    pos1     = pos0 + 1'b1;
    left_end = (left_bits_q != '0) && (pos1 == lb_ext);
    hit_len  = (pos1 == row_len);
    main_end = !left_end && hit_len;
    main_low = row_len[3:0] - left_bits_q;

    flush_en = left_end || (main_end && (bi2 != '0));
    zero_en  = (left_end && !left_bits_q[3]) || (main_end && !main_low[3]);

    num = {1'b0, full} + {1'b0, flush_en} + {1'b0, zero_en};

    push = '0;
    if (full) begin
      push.first.data  = acc1;
      push.second.data = flush_en ? acc2 : 8'h00;
    end else if (flush_en) begin
      push.first.data  = acc2;
      push.second.data = 8'h00;
    end else begin
      push.first.data  = 8'h00;
      push.second.data = 8'h00;
    end
    // Mark the final byte of this pixel.
    push.first.last     = (num == 2'd1);
    push.first.row_end  = (num == 2'd1) && hit_len;
    push.second.last    = 1'b1;
    push.second.row_end = hit_len;
    push.num            = (accept_i && !row_empty) ? num : 2'd0;

    if (row_empty) begin
      pos_d = '0;
      acc_d = '0;
      bi_d  = '0;
    end else begin
      pos_d = hit_len ? '0 : pos1;
      acc_d = (left_end || main_end) ? '0 : acc2;
      bi_d  = (left_end || main_end) ? '0 : bi2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
      bi_q  <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      acc_q <= acc_d;
      bi_q  <= bi_d;
    end
  end

  assign push_o = push;

endmodule

`default_nettype wire

### hw/rtl/thbp_outq.sv
`default_nettype none

// Four-entry result queue: takes up to two bytes a cycle, gives one.
module thbp_outq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  thbp_pkg::push_t      push_i,
  input  wire logic            pop_i,
  output logic                 room_o,
  output logic                 valid_o,
  output thbp_pkg::entry_t     head_o
);

  thbp_pkg::entry_t mem_q [4];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign wr_d    = wr_q + push_i.num;
  assign rd_d    = rd_q + {1'b0, pop};
  assign cnt_d   = cnt_q + {1'b0, push_i.num} - {2'b00, pop};
  assign valid_o = (cnt_q != '0);
  // Two free slots must be there before a pixel is taken.
  assign room_o  = (cnt_q <= 3'd2);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.second;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/threshold_halftone_bit_packer.sv
// Threshold halftoning to 1 bit per pixel with MSB-first byte packing. One pixel request
// (contone and threshold byte) is taken per cycle while s_axis_tready is high; its bit is
// set when contone is below threshold. Each pixel gives zero, one or two bytes, computed
// combinationally and written to a four-entry output queue; the input is ready while the
// queue holds at most two bytes, so a stream of one byte per pixel or less runs at one
// pixel per clock while m_axis_tready is high, and pixels that close a segment with two
// bytes are limited by the output port, which moves one byte per clock. Row geometry
// comes from left_bits (index 0) and row_width (index 1); write them only while idle.
`default_nettype none

module threshold_halftone_bit_packer #(
  parameter int unsigned MaxRowWidth = thbp_pkg::MAX_ROW_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [thbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [thbp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [15:0]                    s_axis_tdata,  // contone_value, threshold_value
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // halftone_byte
  output logic                                m_axis_tlast,  // last_in_run
  output logic                                m_axis_tuser   // row_end
);

  logic             accept;
  thbp_pkg::push_t  push;
  thbp_pkg::entry_t head;

  assign accept = s_axis_tvalid && s_axis_tready;

  thbp_packer #(
    .MaxRowWidth(MaxRowWidth)
  ) u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .contone_i   (s_axis_tdata[7:0]),
    .threshold_i (s_axis_tdata[15:8]),
    .push_o      (push)
  );

  thbp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .head_o  (head)
  );

  assign m_axis_tdata = head.data;
  assign m_axis_tlast = head.last;
  assign m_axis_tuser = head.row_end;

endmodule

`default_nettype wire

### hw/rtl/thbp_checker.sv
`default_nettype none

`include "threshold_halftone_bit_packer_macros.svh"

module thbp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic       m_axis_tuser
);

  `THBP_ASSERT_NXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
                   && $stable(m_axis_tuser), "stalled byte changed")
  `THBP_ASSERT_IMP(a_row_end_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
                   "row end not on last byte of pixel")
  `THBP_ASSERT_IMP(a_stall_has_data, !s_axis_tready, m_axis_tvalid,
                   "input held off with empty queue")
  `THBP_ASSERT_NXT(a_pair_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                   m_axis_tvalid, "second byte of pixel missing")

endmodule

bind threshold_halftone_bit_packer thbp_checker u_thbp_checker (.*);

`default_nettype wire
